@@ sv/motor_dead_zone_ramp_test_core_macros.svh @@
// Assertion macros shared by the dead-zone ramp test RTL.
`ifndef MOTOR_DEAD_ZONE_RAMP_TEST_CORE_MACROS_SVH
`define MOTOR_DEAD_ZONE_RAMP_TEST_CORE_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define MDZ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define MDZ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/mdzrt_pkg.sv @@
// Types and constants of the dead-zone ramp test core.
`timescale 1ns / 1ps
package mdzrt_pkg;

	localparam int MV_W    = 14;
	localparam int CNT_W   = 16;
	localparam int POS_W   = 32;
	localparam int LIM_W   = 20;
	localparam int RUNS_W  = 4;
	localparam int RUN_W   = 5;
	localparam int SCALE_W = 16;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [RUN_W-1:0] RUN_MAX = 5'd16;

	// register indexes, byte address is 4x
	localparam logic [2:0] REG_STEP_TICKS     = 3'd0;
	localparam logic [2:0] REG_STEP_MV        = 3'd1;
	localparam logic [2:0] REG_DISTANCE_LIMIT = 3'd2;
	localparam logic [2:0] REG_WAIT_TICKS     = 3'd3;
	localparam logic [2:0] REG_NUM_RUNS       = 3'd4;
	localparam logic [2:0] REG_DEAD_ZONE_MV   = 3'd5;
	localparam logic [2:0] REG_PWM_SCALE      = 3'd6;

	// reported phase codes
	localparam logic [1:0] PHASE_CODE_RAMP = 2'd0;
	localparam logic [1:0] PHASE_CODE_WAIT = 2'd1;
	localparam logic [1:0] PHASE_CODE_DONE = 2'd2;

	typedef enum logic [2:0] {
		PH_RAMP = 3'b001,
		PH_WAIT = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [CNT_W-1:0]   step_ticks;
		logic [MV_W-1:0]    step_mv;
		logic [LIM_W-1:0]   distance_limit;
		logic [CNT_W-1:0]   wait_ticks;
		logic [RUNS_W-1:0]  num_runs;
		logic [MV_W-1:0]    dead_zone_mv;
		logic [SCALE_W-1:0] pwm_scale;
	} cfg_t;

	typedef struct packed {
		phase_t             phase;
		logic [CNT_W-1:0]   step_count;
		logic [CNT_W-1:0]   wait_count;
		logic [MV_W-1:0]    ramp_mv;
		logic [RUN_W-1:0]   run_count;
		logic [POS_W-1:0]   zero_ref;
		logic [POS_W-1:0]   prev_position;
	} state_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] velocity;
		logic [MV_W-1:0]  drive;
		logic [MV_W-1:0]  duty;
		logic             forward;
		logic [RUN_W-1:0] run_number;
		logic [1:0]       phase;
	} res_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_RAMP: code = PHASE_CODE_RAMP;
			PH_WAIT: code = PHASE_CODE_WAIT;
			PH_DONE: code = PHASE_CODE_DONE;
			default: code = PHASE_CODE_RAMP;
		endcase
		return code;
	endfunction

endpackage

@@ sv/motor_dead_zone_ramp_test_core.sv @@
// Top level of the motor dead-zone ramp test core.
// Result path: input register, then result register, which loads when stage 1 advances.
// Throughput: one item per cycle unless out_ready stalls the result register; set by the single-pass
// step logic between the input register and the result register, which also updates the state.
// Reset (arst_n low, async): config to defaults, test state to ramping with
// run 1, zero reference 0, both pipeline stages empty. No clearing pass.
`timescale 1ns / 1ps
`include "motor_dead_zone_ramp_test_core_macros.svh"
module motor_dead_zone_ramp_test_core import mdzrt_pkg::*; #(
	parameter int VCC_MV = 15000
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [POS_W-1:0]         encoder_count,
	// result channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [POS_W-1:0]  position_counts,
	output logic signed [POS_W-1:0]  velocity_counts,
	output logic [MV_W-1:0]          drive_mv,
	output logic [MV_W-1:0]          pwm_duty,
	output logic                     forward,
	output logic [RUN_W-1:0]         run_number,
	output logic [1:0]               phase,
	// configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	// configuration registers
	cfg_t             cfg_q;
	logic             cfg_wr;
	logic [2:0]       reg_idx;

	// input stage
	logic             valid_s1;
	logic [POS_W-1:0] count_s1;

	// test state, advanced once per item leaving the input stage
	state_t           state_q;
	state_t           state_nxt;

	// result stage
	logic             out_valid_q;
	res_t             res_q;
	res_t             res_nxt;

	logic             advance;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_ticks     <= CNT_W'(100);
			cfg_q.step_mv        <= MV_W'(50);
			cfg_q.distance_limit <= LIM_W'(660);
			cfg_q.wait_ticks     <= CNT_W'(300);
			cfg_q.num_runs       <= RUNS_W'(5);
			cfg_q.dead_zone_mv   <= '0;
			cfg_q.pwm_scale      <= SCALE_W'(21845);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_STEP_TICKS:     cfg_q.step_ticks     <= pwdata[CNT_W-1:0];
				REG_STEP_MV:        cfg_q.step_mv        <= pwdata[MV_W-1:0];
				REG_DISTANCE_LIMIT: cfg_q.distance_limit <= pwdata[LIM_W-1:0];
				REG_WAIT_TICKS:     cfg_q.wait_ticks     <= pwdata[CNT_W-1:0];
				REG_NUM_RUNS:       cfg_q.num_runs       <= pwdata[RUNS_W-1:0];
				REG_DEAD_ZONE_MV:   cfg_q.dead_zone_mv   <= pwdata[MV_W-1:0];
				REG_PWM_SCALE:      cfg_q.pwm_scale      <= pwdata[SCALE_W-1:0];
				default: begin
					// unmapped address: write dropped
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_STEP_TICKS:     prdata = DATA_W'(cfg_q.step_ticks);
			REG_STEP_MV:        prdata = DATA_W'(cfg_q.step_mv);
			REG_DISTANCE_LIMIT: prdata = DATA_W'(cfg_q.distance_limit);
			REG_WAIT_TICKS:     prdata = DATA_W'(cfg_q.wait_ticks);
			REG_NUM_RUNS:       prdata = DATA_W'(cfg_q.num_runs);
			REG_DEAD_ZONE_MV:   prdata = DATA_W'(cfg_q.dead_zone_mv);
			REG_PWM_SCALE:      prdata = DATA_W'(cfg_q.pwm_scale);
			default:            prdata = '0;
		endcase
	end

	// Item in stage 1 moves on when the result register is free or being taken.
	// Input side accepts while stage 1 is empty or empties in the same cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			count_s1 <= encoder_count;
		end
	end

	mdzrt_step #(
		.VCC_MV(VCC_MV)
	) u_step (
		.cfg   (cfg_q),
		.st    (state_q),
		.count (count_s1),
		.nxt   (state_nxt),
		.res   (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_RAMP;
			state_q.step_count    <= '0;
			state_q.wait_count    <= '0;
			state_q.ramp_mv       <= '0;
			state_q.run_count     <= RUN_W'(1);
			state_q.zero_ref      <= '0;
			state_q.prev_position <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign position_counts = res_q.position;
	assign velocity_counts = res_q.velocity;
	assign drive_mv        = res_q.drive;
	assign pwm_duty        = res_q.duty;
	assign forward         = res_q.forward;
	assign run_number      = res_q.run_number;
	assign phase           = res_q.phase;

	// Only a running ramp drives the motor.
	`MDZ_ASSERT_NOW(a_drive_off_unless_ramp, out_valid_q && (res_q.phase != PHASE_CODE_RAMP), res_q.drive == '0, "drive nonzero outside ramp phase")
	// Drive never passes the supply.
	`MDZ_ASSERT_NOW(a_drive_clipped, out_valid_q, res_q.drive <= MV_W'(VCC_MV), "drive above supply")
	// Run counter stays between 1 and 16.
	`MDZ_ASSERT_NOW(a_run_range, 1'b1, (state_q.run_count >= RUN_W'(1)) && (state_q.run_count <= RUN_MAX), "run count out of range")
	// Finished test stays finished.
	`MDZ_ASSERT_NEXT(a_done_sticky, state_q.phase == PH_DONE, state_q.phase == PH_DONE, "left finished phase")

endmodule

@@ sv/mdzrt_step.sv @@
// One control tick: next test state and the result item, combinational.
`timescale 1ns / 1ps
module mdzrt_step import mdzrt_pkg::*; #(
	parameter int VCC_MV = 15000
) (
	input  cfg_t             cfg,
	input  state_t           st,
	input  logic [POS_W-1:0] count,
	output state_t           nxt,
	output res_t             res
);

	localparam logic [MV_W:0]   VCC_WIDE   = (MV_W + 1)'(VCC_MV);
	localparam logic [MV_W-1:0] VCC_NARROW = MV_W'(VCC_MV);

	logic [POS_W-1:0]         pos;
	logic [POS_W-1:0]         vel;
	logic [POS_W-1:0]         mag;
	logic [POS_W-1:0]         rpos;
	logic [POS_W-1:0]         rvel;
	logic [CNT_W-1:0]         scnt;
	logic [CNT_W-1:0]         wcnt;
	logic [MV_W:0]            rsum;
	logic [MV_W-1:0]          ramp;
	logic [RUN_W-1:0]         run;
	logic [MV_W-1:0]          u;
	logic [MV_W:0]            dsum;
	logic [MV_W-1:0]          drive;
	logic [MV_W+SCALE_W-1:0]  prod;

	assign pos  = count - st.zero_ref;
	assign vel  = pos - st.prev_position;
	assign mag  = pos[POS_W-1] ? (~pos + POS_W'(1)) : pos;
	assign scnt = st.step_count + CNT_W'(1);
	assign wcnt = st.wait_count + CNT_W'(1);
	assign rsum = {1'b0, st.ramp_mv} + {1'b0, cfg.step_mv};
	assign run  = (st.run_count < RUN_MAX) ? (st.run_count + RUN_W'(1)) : st.run_count;

	always_comb begin
		nxt               = st;
		nxt.prev_position = pos;
		rpos              = pos;
		rvel              = vel;
		ramp              = st.ramp_mv;
		u                 = '0;
		case (st.phase)
			PH_WAIT: begin
				rpos              = '0;
				rvel              = '0;
				nxt.prev_position = '0;
				nxt.wait_count    = wcnt;
				if (wcnt >= cfg.wait_ticks) begin
					nxt.phase      = PH_RAMP;
					nxt.wait_count = '0;
					nxt.zero_ref   = count;
					nxt.ramp_mv    = '0;
					nxt.step_count = '0;
				end
			end
			PH_RAMP: begin
				nxt.step_count = scnt;
				if (scnt >= cfg.step_ticks) begin
					nxt.step_count = '0;
					ramp = (rsum > VCC_WIDE) ? VCC_NARROW : rsum[MV_W-1:0];
				end
				nxt.ramp_mv = ramp;
				if (mag > {{(POS_W-LIM_W){1'b0}}, cfg.distance_limit}) begin
					// run end: measured values still reported, drive off
					nxt.run_count = run;
					if (run > {1'b0, cfg.num_runs}) begin
						nxt.phase = PH_DONE;
					end else begin
						nxt.phase      = PH_WAIT;
						nxt.wait_count = '0;
					end
				end else begin
					u = ramp;
				end
			end
			default: begin
				// finished: measure only
			end
		endcase
	end

	assign dsum  = {1'b0, u} + {1'b0, cfg.dead_zone_mv};
	assign drive = (u == '0) ? '0 : ((dsum > VCC_WIDE) ? VCC_NARROW : dsum[MV_W-1:0]);
	assign prod  = {{SCALE_W{1'b0}}, drive} * {{MV_W{1'b0}}, cfg.pwm_scale};

	assign res.position   = rpos;
	assign res.velocity   = rvel;
	assign res.drive      = drive;
	assign res.duty       = prod[MV_W+SCALE_W-1:SCALE_W];
	assign res.forward    = (prod[MV_W+SCALE_W-1:SCALE_W] != '0);
	assign res.run_number = nxt.run_count;
	assign res.phase      = phase_code(nxt.phase);

endmodule

@@ verif/ramp_test_checker.sv @@
// Checker for the dead-zone ramp test core: predicts every tick report and compares it.
`timescale 1ns / 1ps
module ramp_test_checker import mdzrt_pkg::*; #(
	parameter int unsigned SUPPLY_MV = 15000
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [POS_W-1:0]        encoder_count,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic signed [POS_W-1:0] position_counts,
	input  logic signed [POS_W-1:0] velocity_counts,
	input  logic [MV_W-1:0]         drive_mv,
	input  logic [MV_W-1:0]         pwm_duty,
	input  logic                    forward,
	input  logic [RUN_W-1:0]        run_number,
	input  logic [1:0]              phase,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic                    pready,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output int                      mismatches,
	output int                      reports_pending,
	output int                      reports_checked,
	output int                      run_ends,
	output logic                    finish_seen
);

	// register mirror and test state
	cfg_t             cfg;
	phase_t           test_ph;
	logic [CNT_W-1:0] step_cnt;
	logic [CNT_W-1:0] wait_cnt;
	logic [MV_W-1:0]  ramp;
	logic [RUN_W-1:0] run_cnt;
	logic [POS_W-1:0] zero_ref;
	logic [POS_W-1:0] prev_pos;

	res_t tick_reports_q[$];

	// one control tick: update state, build the report
	task automatic advance_tick(input logic [POS_W-1:0] cnt, output res_t rep);
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] vel;
		logic [POS_W-1:0] mag;
		int unsigned      sum;
		int unsigned      drv;
		logic [47:0]      prod;
		pos = cnt - zero_ref;
		vel = pos - prev_pos;
		prev_pos = pos;
		drv = 0;
		case (test_ph)
			PH_WAIT: begin
				pos = '0;
				vel = '0;
				prev_pos = '0;
				wait_cnt = wait_cnt + 1'b1;
				if (wait_cnt >= cfg.wait_ticks) begin
					test_ph = PH_RAMP;
					wait_cnt = '0;
					zero_ref = cnt;
					ramp = '0;
					step_cnt = '0;
				end
			end
			PH_RAMP: begin
				step_cnt = step_cnt + 1'b1;
				if (step_cnt >= cfg.step_ticks) begin
					step_cnt = '0;
					sum = ramp + cfg.step_mv;
					if (sum > SUPPLY_MV)
						sum = SUPPLY_MV;
					ramp = MV_W'(sum);
				end
				// most negative position counts as 2^31
				mag = pos[POS_W-1] ? (32'd0 - pos) : pos;
				if (mag > POS_W'(cfg.distance_limit)) begin
					if (run_cnt < RUN_MAX)
						run_cnt = run_cnt + 1'b1;
					run_ends++;
					if (run_cnt > RUN_W'(cfg.num_runs)) begin
						test_ph = PH_DONE;
						finish_seen = 1'b1;
					end else begin
						test_ph = PH_WAIT;
						wait_cnt = '0;
					end
				end else begin
					drv = ramp;
				end
			end
			default: ;
		endcase
		if (drv != 0) begin
			drv = drv + cfg.dead_zone_mv;
			if (drv > SUPPLY_MV)
				drv = SUPPLY_MV;
		end
		prod = 48'(drv) * 48'(cfg.pwm_scale);
		rep.position = pos;
		rep.velocity = vel;
		rep.drive = MV_W'(drv);
		rep.duty = prod[16+MV_W-1:16];
		rep.forward = |prod[16+MV_W-1:16];
		rep.run_number = run_cnt;
		case (test_ph)
			PH_WAIT: rep.phase = PHASE_CODE_WAIT;
			PH_DONE: rep.phase = PHASE_CODE_DONE;
			default: rep.phase = PHASE_CODE_RAMP;
		endcase
	endtask

	task automatic check_field(input string name, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t rep;
		res_t want;
		if (!arst_n) begin
			cfg.step_ticks = 16'd100;
			cfg.step_mv = 14'd50;
			cfg.distance_limit = 20'd660;
			cfg.wait_ticks = 16'd300;
			cfg.num_runs = 4'd5;
			cfg.dead_zone_mv = 14'd0;
			cfg.pwm_scale = 16'd21845;
			test_ph = PH_RAMP;
			step_cnt = '0;
			wait_cnt = '0;
			ramp = '0;
			run_cnt = 5'd1;
			zero_ref = '0;
			prev_pos = '0;
			tick_reports_q.delete();
			mismatches = 0;
			reports_pending = 0;
			reports_checked = 0;
			run_ends = 0;
			finish_seen = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (tick_reports_q.size() == 0) begin
					$error("tick report with no tick waiting");
					mismatches++;
				end else begin
					want = tick_reports_q.pop_front();
					check_field("position_counts", want.position, position_counts);
					check_field("velocity_counts", want.velocity, velocity_counts);
					check_field("drive_mv", POS_W'(want.drive), POS_W'(drive_mv));
					check_field("pwm_duty", POS_W'(want.duty), POS_W'(pwm_duty));
					check_field("forward", POS_W'(want.forward), POS_W'(forward));
					check_field("run_number", POS_W'(want.run_number), POS_W'(run_number));
					check_field("phase", POS_W'(want.phase), POS_W'(phase));
					reports_checked++;
				end
			end
			if (in_valid && in_ready) begin
				advance_tick(encoder_count, rep);
				tick_reports_q.push_back(rep);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_STEP_TICKS:     cfg.step_ticks = pwdata[CNT_W-1:0];
					REG_STEP_MV:        cfg.step_mv = pwdata[MV_W-1:0];
					REG_DISTANCE_LIMIT: cfg.distance_limit = pwdata[LIM_W-1:0];
					REG_WAIT_TICKS:     cfg.wait_ticks = pwdata[CNT_W-1:0];
					REG_NUM_RUNS:       cfg.num_runs = pwdata[RUNS_W-1:0];
					REG_DEAD_ZONE_MV:   cfg.dead_zone_mv = pwdata[MV_W-1:0];
					REG_PWM_SCALE:      cfg.pwm_scale = pwdata[SCALE_W-1:0];
					default: ;
				endcase
			end
			reports_pending = tick_reports_q.size();
		end
	end

endmodule

@@ verif/motor_dead_zone_ramp_test_core_tb.sv @@
// Testbench top for the dead-zone ramp test core: stimulus, handshakes and verdict.
`timescale 1ns / 1ps
module motor_dead_zone_ramp_test_core_tb;
	import mdzrt_pkg::*;

	localparam int unsigned SUPPLY_MV = 15000;
	localparam int SEGMENTS = 8;        // random phases, each under its own settings
	localparam int SEG_TICKS = 125;     // ticks per random phase

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [POS_W-1:0]        encoder_count;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [POS_W-1:0] position_counts;
	logic signed [POS_W-1:0] velocity_counts;
	logic [MV_W-1:0]         drive_mv;
	logic [MV_W-1:0]         pwm_duty;
	logic                    forward;
	logic [RUN_W-1:0]        run_number;
	logic [1:0]              phase;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [DATA_W-1:0]       pwdata;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;

	// checker status
	int   mismatches;
	int   reports_pending;
	int   reports_checked;
	int   run_ends;
	logic finish_seen;

	// sender bookkeeping
	int ticks_sent = 0;
	int settings_used = 1;   // reset defaults count as the first setting
	int burst_left = 1;

	logic [15:0] rx_cycle = '0;

	motor_dead_zone_ramp_test_core #(.VCC_MV(SUPPLY_MV)) dut (.*);

	ramp_test_checker #(.SUPPLY_MV(SUPPLY_MV)) tick_check (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Receiver: stall pattern chosen by rx_cycle[9:8] - always ready,
	// one stall in four, random stalls, then alternating stall and ready stretches.
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1'b1;
		case (rx_cycle[9:8])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= (rx_cycle[1:0] != 2'd3);
			2'd2: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ~rx_cycle[4];
		endcase
	end

	// APB write: setup cycle, access cycle, then an idle cycle so that
	// back-to-back writes never drop and raise psel in the same step.
	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Present one encoder reading and hold it until accepted. Bursts of
	// random length, random gaps between them, some bursts run back to back.
	task automatic send_tick(input logic [POS_W-1:0] cnt);
		int gap;
		in_valid <= 1'b1;
		encoder_count <= cnt;
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop sending and wait for every tick report, then let the two-stage
	// pipeline settle. Called in the step of the last accept, so valid drops
	// before a second copy of the item can go in.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (reports_pending != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		int seg;
		int k;
		int reach;
		int speed;
		int delta;
		int roll;
		logic backward;
		logic [POS_W-1:0] shaft;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		encoder_count <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- Directed part ---------------------------------------------------
		// Reset defaults: small travel on both sides of zero, up to the
		// distance limit exactly (no run end), count wrapping below zero.
		send_tick(32'd0);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'd660);
		send_tick(32'hFFFF_FD6C);
		send_tick(32'd1);

		// Step on every tick, biggest step so the ramp saturates at the supply,
		// largest dead zone (clip), full PWM scale, widest limit, no wait.
		wait_drained();
		write_reg(REG_STEP_TICKS, 0);
		write_reg(REG_STEP_MV, 15000);
		write_reg(REG_DISTANCE_LIMIT, 20'hF_FFFF);
		write_reg(REG_WAIT_TICKS, 0);
		write_reg(REG_NUM_RUNS, 15);
		write_reg(REG_DEAD_ZONE_MV, 15000);
		write_reg(REG_PWM_SCALE, 16'hFFFF);
		settings_used++;
		send_tick(32'd100);
		send_tick(32'h000F_FFFF);      // travel equal to the limit, both signs
		send_tick(32'hFFF0_0001);
		send_tick(32'h8000_0000);      // most negative position ends the run
		send_tick(32'h7FFF_FFFF);      // zero wait: re-zero right away
		send_tick(32'hFFFF_FFFF);      // position 0x80000000 again
		send_tick(32'd0);
		send_tick(32'h0010_0000);      // one count past the limit
		send_tick(32'd0);

		// Tiny drive with zero PWM scale: drive nonzero, forward stays low.
		// Zero distance limit, longest wait.
		wait_drained();
		write_reg(REG_STEP_TICKS, 1);
		write_reg(REG_STEP_MV, 1);
		write_reg(REG_DISTANCE_LIMIT, 0);
		write_reg(REG_WAIT_TICKS, 16'hFFFF);
		write_reg(REG_DEAD_ZONE_MV, 0);
		write_reg(REG_PWM_SCALE, 0);
		settings_used++;
		send_tick(32'd0);
		send_tick(32'd0);
		send_tick(32'd1);               // any travel ends the run
		send_tick(32'd42);
		send_tick(32'd43);
		send_tick(32'd44);

		// Wait limit lowered under the running counter: the wait ends on the
		// next tick. Step interval raised to its maximum.
		wait_drained();
		write_reg(REG_WAIT_TICKS, 2);
		write_reg(REG_STEP_TICKS, 16'hFFFF);
		write_reg(REG_DISTANCE_LIMIT, 100);
		write_reg(REG_PWM_SCALE, 1);
		settings_used++;
		send_tick(32'd5);
		send_tick(32'd5);
		send_tick(32'd6);

		// Step interval lowered under the step counter: step on the next tick.
		wait_drained();
		write_reg(REG_STEP_TICKS, 1);
		settings_used++;
		send_tick(32'd7);
		send_tick(32'd7);

		// --- Random part -----------------------------------------------------
		// The shaft mostly moves steadily in one direction so that runs end by
		// real travel; rare glitch readings and short reversals are mixed in.
		// The last phase sets zero runs: the next run end finishes the test.
		shaft = $urandom;
		for (seg = 0; seg < SEGMENTS; seg++) begin
			wait_drained();
			reach = $urandom_range(200, 4000);
			speed = reach / 90 + 1;
			backward = $urandom_range(0, 1);
			write_reg(REG_STEP_TICKS, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20));
			write_reg(REG_STEP_MV, ($urandom_range(0, 7) == 0) ? 15000 : $urandom_range(0, 600));
			write_reg(REG_DISTANCE_LIMIT, reach);
			write_reg(REG_WAIT_TICKS, $urandom_range(0, 40));
			write_reg(REG_NUM_RUNS, (seg == SEGMENTS - 1) ? 0 : 15);
			write_reg(REG_DEAD_ZONE_MV,
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 15000) : $urandom_range(0, 800));
			write_reg(REG_PWM_SCALE, $urandom_range(0, 65535));
			settings_used++;
			for (k = 0; k < SEG_TICKS; k++) begin
				roll = $urandom_range(0, 199);
				if (roll == 0) begin
					// glitch reading, the shaft itself does not move
					send_tick($urandom);
				end else begin
					delta = $urandom_range(0, 2 * speed) - speed / 3;
					if (roll < 6)
						delta = -delta;        // short reversal
					shaft = backward ? shaft - delta : shaft + delta;
					send_tick(shaft);
				end
				// now and then hold the sender until the block is empty
				if ($urandom_range(0, 299) == 0)
					wait_drained();
			end
		end

		wait_drained();
		$display("Coverage: %0d ticks under %0d register settings, %0d tick reports checked",
			ticks_sent, settings_used, reports_checked);
		$display("Coverage: %0d run ends, finished phase %s", run_ends,
			finish_seen ? "reached" : "not reached");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
